/* hdl/arp_pkg.sv */
// package: shared codes, types and defaults for the arp cache and responder
`timescale 1ns / 1ps

package arp_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;

  localparam logic [1:0] MODE_RX      = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
  localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

  localparam logic [15:0] ARP_OPC_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OPC_REPLY   = 16'd2;
  localparam logic [15:0] HTYPE_ETHERNET  = 16'd1;
  localparam logic [15:0] PTYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  HLEN_ETHERNET   = 8'd6;
  localparam logic [7:0]  PLEN_IPV4       = 8'd4;
  localparam logic [15:0] MIN_PACKET_LEN  = 16'd28;

  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_FINISH
  } arp_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LEARN,
    OP_LOOKUP,
    OP_REQUEST
  } arp_op_t;

endpackage

/* hdl/arp_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module arp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/arp_cache_and_responder.sv */
// top level: arp cache with learning, lookup, reply and request generation
//
//  channel | direction | handshake              | carries
//  in      | into      | in_valid / in_stall    | one request: mode and arp header fields
//  out     | out of    | out_valid / out_stall  | one result per request
//  cfg     | into      | apb psel/penable/pready| own_ip at 0x0, own_mac at 0x8
//
// a learnt packet or lookup scans the cache ram one entry a cycle, set by its single read port,
// then passes drain, write (learnt packets only) and finish; the next request is taken only
// once finish has handed on the result; other requests go straight to finish
// synchronous reset clears the valid bits, config registers and control; no clearing pass
// a new request is taken while a finished result waits on out_stall
`timescale 1ns / 1ps

module arp_cache_and_responder
  import arp_pkg::*;
#(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] frame_len,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_addr_len,
  input  logic [7:0]  proto_addr_len,
  input  logic [15:0] opcode,
  input  logic [47:0] snd_mac,
  input  logic [31:0] snd_ip,
  input  logic [31:0] tgt_ip,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [47:0] frame_dest_mac,
  output logic [1:0]  frame_opcode,
  output logic [47:0] frame_tgt_mac,
  output logic [31:0] frame_tgt_ip,
  output logic        lookup_hit,
  output logic [47:0] lookup_mac,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);

  // configuration registers
  logic [31:0] own_ip;
  logic [47:0] own_mac;

  // fsm
  arp_state_t state, state_next;

  // request held during the scan
  arp_op_t     op;
  logic [31:0] key_ip;
  logic [47:0] key_mac;
  logic        reply;
  logic [31:0] req_ip;

  // scan bookkeeping
  logic [IdxW-1:0] scan_cnt;
  logic            rd_pend;
  logic [IdxW-1:0] rd_idx;
  logic            found;
  logic [IdxW-1:0] match_idx;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic [47:0]     hit_mac;

  logic [CACHE_ENTRIES-1:0] entry_valid;

  // ram port signals
  logic            ram_we;
  logic [IdxW-1:0] wr_addr;
  logic [79:0]     ram_rdata;
  logic [31:0]     rd_ip;
  logic [47:0]     rd_mac;

  // control
  logic    in_accept;
  logic    out_free;
  logic    out_load;
  logic    scan_issue;
  logic    hdr_ok;
  arp_op_t accept_op;
  logic    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_OWN_IP:  own_ip  <= pwdata[31:0];
        REG_OWN_MAC: own_mac <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_OWN_IP:  prdata = {32'd0, own_ip};
      REG_OWN_MAC: prdata = {16'd0, own_mac};
      default:     prdata = '0;
    endcase
  end

  assign hdr_ok = (frame_len >= MIN_PACKET_LEN) && (hw_type == HTYPE_ETHERNET) &&
                  (proto_type == PTYPE_IPV4) && (hw_addr_len == HLEN_ETHERNET) &&
                  (proto_addr_len == PLEN_IPV4);

  always_comb begin
    unique case (mode)
      MODE_RX:      accept_op = hdr_ok ? OP_LEARN : OP_NONE;
      MODE_LOOKUP:  accept_op = OP_LOOKUP;
      MODE_REQUEST: accept_op = OP_REQUEST;
      default:      accept_op = OP_NONE;
    endcase
  end

  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (accept_op == OP_LEARN || accept_op == OP_LOOKUP) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt == LastIdx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = (op == OP_LEARN) ? ST_WRITE : ST_FINISH;
      end
      ST_WRITE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall   = 1'b1;
    scan_issue = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall   = 1'b0;
      ST_SCAN:   scan_issue = 1'b1;
      ST_DRAIN:  ;
      ST_WRITE:  ram_we     = 1'b1;
      ST_FINISH: out_load   = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // matching entry first, else lowest free slot, else slot 0
  assign wr_addr = found ? match_idx : (free_found ? free_idx : '0);

  arp_ram #(
    .WIDTH (80),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata ({key_ip, key_mac}),
    .raddr (scan_cnt),
    .rdata (ram_rdata)
  );

  assign rd_ip  = ram_rdata[79:48];
  assign rd_mac = ram_rdata[47:0];

  // request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_NONE;
    end else if (in_accept) begin
      op <= accept_op;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_ip  <= (mode == MODE_LOOKUP) ? tgt_ip : snd_ip;
      key_mac <= snd_mac;
      reply   <= (opcode == ARP_OPC_REQUEST) && (tgt_ip == own_ip);
      req_ip  <= tgt_ip;
    end
  end

  // scan: address issued one cycle, compared the next
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      rd_pend    <= 1'b0;
      rd_idx     <= '0;
      found      <= 1'b0;
      match_idx  <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else begin
      rd_pend <= scan_issue;
      if (in_accept) begin
        scan_cnt   <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else if (scan_issue) begin
        rd_idx <= scan_cnt;
        if (scan_cnt != LastIdx) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
      end
      if (rd_pend) begin
        if (entry_valid[rd_idx] && rd_ip == key_ip && !found) begin
          found     <= 1'b1;
          match_idx <= rd_idx;
        end
        if (!entry_valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend && entry_valid[rd_idx] && rd_ip == key_ip && !found) begin
      hit_mac <= rd_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind    <= KIND_NONE;
      frame_dest_mac <= '0;
      frame_opcode   <= '0;
      frame_tgt_mac  <= '0;
      frame_tgt_ip   <= '0;
      lookup_hit     <= 1'b0;
      lookup_mac     <= '0;
      case (op)
        OP_LEARN: begin
          if (reply) begin
            result_kind    <= KIND_FRAME;
            frame_dest_mac <= key_mac;
            frame_opcode   <= FRAME_OP_REPLY;
            frame_tgt_mac  <= key_mac;
            frame_tgt_ip   <= key_ip;
          end
        end
        OP_LOOKUP: begin
          result_kind <= KIND_LOOKUP;
          lookup_hit  <= found;
          lookup_mac  <= found ? hit_mac : '0;
        end
        OP_REQUEST: begin
          result_kind    <= KIND_FRAME;
          frame_dest_mac <= MAC_BROADCAST;
          frame_opcode   <= FRAME_OP_REQUEST;
          frame_tgt_ip   <= req_ip;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a written slot is valid afterwards
  assert property (@(posedge clk) disable iff (rst)
    ram_we |=> entry_valid[$past(wr_addr)])
    else $error("written cache slot not marked valid");

  // a recorded match points at a valid entry when the write happens
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && found) |-> entry_valid[match_idx])
    else $error("match index points at invalid entry");

  // a recorded free slot is still free when it is filled
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !found && free_found) |-> !entry_valid[free_idx])
    else $error("free slot already valid");

  // a lookup miss carries no mac
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !lookup_hit) |-> (lookup_mac == '0))
    else $error("lookup miss with non-zero mac");

  // the cache ram is only written for a learnt packet
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (op == OP_LEARN && $past(state) == ST_DRAIN))
    else $error("cache write outside learning");
`endif

endmodule
